FILE: rtl/core/dq_pkg.sv
// shared types, sizes and helpers of the double-ended queue
package dq_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;

  localparam int PTR_W    = $clog2(DEPTH);
  localparam int SUM_W    = PTR_W + 1;
  localparam int CNT_W    = $clog2(DEPTH) + 1;
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int LEN_W    = 9;
  localparam int STATUS_W = 2;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // operation in the upper two bits of func, the low bit picks the tail end
  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_INDEX  = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_ZERO = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_SHIFT,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] result_value;
    status_e            status;
    logic [LEN_W-1:0]   length;
  } done_t;

  // ring slot of logical entry k
  function automatic ptr_t slot_of(input ptr_t base, input ptr_t k);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, k};
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

FILE: rtl/core/dq_in_if.sv
// request channel of the double-ended queue
interface dq_in_if;
  import dq_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);
endinterface

FILE: rtl/core/dq_out_if.sv
// result channel of the double-ended queue
interface dq_out_if;
  import dq_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  result_value;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    length;

  modport source (output valid, output result_value, output status, output length,
                  input ready);
  modport sink   (input valid, input result_value, input status, input length,
                  output ready);
endinterface

FILE: rtl/core/dq_ram.sv
// entry store: one write port, one read port with registered read data
module dq_ram (
  input  logic         clk_i,
  input  logic         we_i,
  input  dq_pkg::ptr_t wr_addr_i,
  input  dq_pkg::word_t wr_data_i,
  input  logic         rd_en_i,
  input  dq_pkg::ptr_t rd_addr_i,
  output dq_pkg::word_t rd_data_o
);
  import dq_pkg::*;

  word_t mem_q [DEPTH];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/dq_ctrl.sv
// sequencer: pointers, search compare and gap-closing shift over the entry store
module dq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            func_i,
  input  logic [31:0]           value_i,
  input  logic [7:0]            position_i,
  input  logic                  out_free_i,
  output dq_pkg::done_t         done_o,
  output logic                  we_o,
  output dq_pkg::ptr_t          wr_addr_o,
  output dq_pkg::word_t         wr_data_o,
  output logic                  rd_en_o,
  output dq_pkg::ptr_t          rd_addr_o,
  input  dq_pkg::word_t         rd_data_i
);
  import dq_pkg::*;

  state_e state_q, state_d;
  ptr_t   front_q, front_d;
  cnt_t   count_q, count_d;
  ptr_t   k_q, k_d;
  logic   tail_q, tail_d;
  word_t  val_q, val_d;
  logic [VALUE_W-1:0] hold_val_q, hold_val_d;
  status_e hold_st_q, hold_st_d;

  op_e    op;
  logic   at_tail;
  word_t  v_in;
  logic   v_zero;
  ptr_t   cnt_m1;
  ptr_t   front_inc;
  ptr_t   front_dec;
  ptr_t   pos_p;
  logic   fin;
  logic [VALUE_W-1:0] fin_value;
  status_e fin_status;
  logic   hit;
  logic   last;

  assign op        = op_e'(func_i[2:1]);
  assign at_tail   = func_i[0];
  assign v_in      = value_i[DATA_WIDTH-1:0];
  assign v_zero    = (v_in == '0);
  assign cnt_m1    = PTR_W'(count_q - CNT_W'(1));
  assign front_inc = slot_of(front_q, PTR_W'(1));
  assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - PTR_W'(1);
  assign pos_p     = PTR_W'(position_i);
  assign hit       = (rd_data_i == val_q);
  assign last      = tail_q ? (k_q == '0) : (k_q == cnt_m1);
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    tail_q     <= tail_d;
    val_q      <= val_d;
    hold_val_q <= hold_val_d;
    hold_st_q  <= hold_st_d;
  end

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    k_d        = k_q;
    tail_d     = tail_q;
    val_d      = val_q;
    hold_val_d = hold_val_q;
    hold_st_d  = hold_st_q;
    we_o       = 1'b0;
    wr_addr_o  = front_q;
    wr_data_o  = v_in;
    rd_en_o    = 1'b0;
    rd_addr_o  = front_q;
    fin        = 1'b0;
    fin_value  = '0;
    fin_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_PUT: begin
              fin = 1'b1;
              if (v_zero) begin
                fin_status = ST_ZERO;
              end else if (count_q == CNT_W'(DEPTH)) begin
                fin_status = ST_FULL;
              end else begin
                we_o    = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (at_tail) begin
                  wr_addr_o = slot_of(front_q, count_q[PTR_W-1:0]);
                end else begin
                  wr_addr_o = front_dec;
                  front_d   = front_dec;
                end
              end
            end
            OP_GET: begin
              if (count_q == '0) begin
                fin        = 1'b1;
                fin_status = ST_MISS;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = at_tail ? slot_of(front_q, cnt_m1) : front_q;
                count_d   = count_q - CNT_W'(1);
                if (!at_tail) begin
                  front_d = front_inc;
                end
                state_d = S_READ;
              end
            end
            OP_INDEX: begin
              if (32'(position_i) >= 32'(count_q)) begin
                fin        = 1'b1;
                fin_status = ST_MISS;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = slot_of(front_q, at_tail ? (cnt_m1 - pos_p) : pos_p);
                state_d   = S_READ;
              end
            end
            OP_REMOVE: begin
              if (v_zero) begin
                fin        = 1'b1;
                fin_status = ST_ZERO;
              end else if (count_q == '0) begin
                fin        = 1'b1;
                fin_status = ST_MISS;
              end else begin
                val_d     = v_in;
                tail_d    = at_tail;
                k_d       = at_tail ? cnt_m1 : '0;
                rd_en_o   = 1'b1;
                rd_addr_o = slot_of(front_q, at_tail ? cnt_m1 : '0);
                state_d   = S_SEARCH;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = ST_MISS;
            end
          endcase
        end
      end
      S_READ: begin
        fin       = 1'b1;
        fin_value = VALUE_W'(rd_data_i);
      end
      // rd_data holds logical entry k_q; the next read is issued alongside
      S_SEARCH: begin
        if (hit) begin
          if (k_q == cnt_m1) begin
            count_d   = count_q - CNT_W'(1);
            fin       = 1'b1;
            fin_value = VALUE_W'(val_q);
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = slot_of(front_q, k_q + PTR_W'(1));
            state_d   = S_SHIFT;
          end
        end else if (last) begin
          fin        = 1'b1;
          fin_status = ST_MISS;
        end else begin
          k_d       = tail_q ? (k_q - PTR_W'(1)) : (k_q + PTR_W'(1));
          rd_en_o   = 1'b1;
          rd_addr_o = slot_of(front_q, tail_q ? (k_q - PTR_W'(1)) : (k_q + PTR_W'(1)));
        end
      end
      // entry k_q+1 arrives and moves down to k_q
      S_SHIFT: begin
        we_o      = 1'b1;
        wr_addr_o = slot_of(front_q, k_q);
        wr_data_o = rd_data_i;
        if (k_q + PTR_W'(1) == cnt_m1) begin
          count_d   = count_q - CNT_W'(1);
          fin       = 1'b1;
          fin_value = VALUE_W'(val_q);
        end else begin
          k_d       = k_q + PTR_W'(1);
          rd_en_o   = 1'b1;
          rd_addr_o = slot_of(front_q, k_q + PTR_W'(2));
        end
      end
      S_HOLD: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // result waits here when the output register is still occupied
    if (fin) begin
      hold_val_d = fin_value;
      hold_st_d  = fin_status;
      state_d    = out_free_i ? S_IDLE : S_HOLD;
    end
  end

  always_comb begin
    done_o.valid        = fin || (state_q == S_HOLD);
    done_o.result_value = (state_q == S_HOLD) ? hold_val_q : fin_value;
    done_o.status       = (state_q == S_HOLD) ? hold_st_q : fin_status;
    done_o.length       = LEN_W'(count_d);
  end

endmodule

FILE: rtl/core/double_ended_queue_top.sv
// Bounded double-ended queue of 256 words held as a ring buffer, one operation per request
// and one result per request. Puts, and any request rejected for a zero word, a full store,
// an empty store or an index out of range, finish in the cycle they are accepted; gets and
// index reads finish in S_READ, once the registered read of the entry store returns the
// entry. A remove compares one entry at a time while searching from the chosen end
// (S_SEARCH), then moves one entry at a time to close the gap (S_SHIFT); the single read
// port of the store sets this pace. A new request is taken whenever the sequencer is idle,
// even while the previous result still sits in the output register.
module double_ended_queue_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);
  import dq_pkg::*;

  done_t done;
  logic  out_free;
  logic  we;
  ptr_t  wr_addr;
  word_t wr_data;
  logic  rd_en;
  ptr_t  rd_addr;
  word_t rd_data;

  logic                out_valid_q;
  logic [VALUE_W-1:0]  out_value_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [LEN_W-1:0]    out_length_q;

  assign out_free = !out_valid_q || out_o.ready;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .func_i     (in_i.func),
    .value_i    (in_i.value),
    .position_i (in_i.position),
    .out_free_i (out_free),
    .done_o     (done),
    .we_o       (we),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  dq_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= done.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && done.valid) begin
      out_value_q  <= done.result_value;
      out_status_q <= done.status;
      out_length_q <= done.length;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_value_q;
  assign out_o.status       = out_status_q;
  assign out_o.length       = out_length_q;

endmodule
